// ===== rtl/multi_pattern_matcher_top_defines.svh =====
`ifndef MULTI_PATTERN_MATCHER_TOP_DEFINES_SVH
`define MULTI_PATTERN_MATCHER_TOP_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define MPM_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// Condition that, once true, must be followed by the consequent in the next cycle.
`define MPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence violated");

`endif

// ===== rtl/mpm_pkg.sv =====
`default_nettype none

package mpm_pkg;

    localparam int OP_W     = 2;
    localparam int SYM_W    = 5;
    localparam int ID_W     = 10;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PAT_SYM = 2'd0,
        OP_PAT_END = 2'd1,
        OP_TEXT    = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK                = 3'd0,
        ST_TRIE_FULL         = 3'd1,
        ST_BAD_SYMBOL        = 3'd2,
        ST_PATTERN_AFTER_TXT = 3'd3,
        ST_BAD_ID            = 3'd4
    } status_t;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_PAT, S_END, S_QUERY,
        S_GO, S_GOX, S_GOX2, S_GORET,
        S_FCHK, S_FCHK2, S_FTOP, S_FTOP2, S_FY, S_FY2, S_FP, S_FP2,
        S_FX, S_FX2, S_PUSH, S_POP, S_FRET, S_FRET2,
        S_WALK, S_WCHK, S_WK, S_WK2, S_MARK, S_MARK2,
        S_DSTART, S_DS2, S_DRET, S_DLOOP, S_DL2, S_FIN
    } step_t;

    typedef enum logic {
        RET_GO,
        RET_DICT
    } ret_t;

    typedef struct packed {
        step_t step;
        logic  in_take;
    } mpm_cmd_t;

    typedef struct packed {
        logic clr_done;
        op_t  op;
        logic err;
        logic trans_hit;
        logic child_hit;
        logic gx_zero;
        logic x_zero;
        logic fail_hit;
        logic y_term;
        logic sp_zero;
        logic stack_full;
        logic u_zero;
        logic w_zero;
        logic nfp_hit;
        logic found_hit;
        logic chain_hit;
        logic dict_hit;
        logic out_free;
    } mpm_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mpm_ctrl.sv =====
`default_nettype none

module mpm_ctrl
    import mpm_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    input  mpm_stat_t stat,
    input  wire       in_valid,
    output logic      in_ready,
    output mpm_cmd_t  cmd
);

    step_t state_reg, state_next;
    ret_t  ret_reg, ret_next;
    step_t ret_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg   <= RET_GO;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign ret_step = (ret_reg == RET_GO) ? S_GORET : S_DRET;

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        in_ready    = 1'b0;
        cmd.step    = state_reg;
        cmd.in_take = 1'b0;
        unique case (state_reg)
            S_CLEAR:  if (stat.clr_done) state_next = S_IDLE;
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_take = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.err)
                    state_next = S_FIN;
                else
                begin
                    unique case (stat.op)
                        OP_PAT_SYM: state_next = S_PAT;
                        OP_PAT_END: state_next = S_END;
                        OP_TEXT:    state_next = S_GO;
                        OP_QUERY:   state_next = S_QUERY;
                    endcase
                end
            end
            S_PAT, S_END, S_QUERY: state_next = S_FIN;
            S_GO:     state_next = stat.trans_hit ? S_WALK : S_GOX;
            S_GOX:    state_next = S_GOX2;
            S_GOX2:
            begin
                if (stat.child_hit || stat.gx_zero)
                    state_next = S_WALK;
                else
                begin
                    ret_next   = RET_GO;
                    state_next = S_FCHK;
                end
            end
            S_GORET:  state_next = S_GOX;
            S_FCHK:   state_next = S_FCHK2;
            S_FCHK2:  state_next = stat.fail_hit ? ret_step : S_FY;
            S_FTOP:   state_next = stat.sp_zero ? S_FRET : S_FTOP2;
            S_FTOP2:  state_next = S_FY;
            S_FY:     state_next = S_FY2;
            S_FY2:    state_next = (stat.fail_hit || stat.y_term) ? S_POP : S_FP;
            S_FP:     state_next = S_FP2;
            S_FP2:    state_next = stat.fail_hit ? S_FX : S_PUSH;
            S_FX:     state_next = S_FX2;
            S_FX2:
            begin
                priority if (stat.child_hit || stat.x_zero)
                    state_next = S_POP;
                else if (!stat.fail_hit)
                    state_next = S_PUSH;
                else
                    state_next = S_FX;
            end
            S_PUSH:   state_next = stat.stack_full ? S_POP : S_FY;
            S_POP:    state_next = S_FTOP;
            S_FRET:   state_next = S_FRET2;
            S_FRET2:  state_next = ret_step;
            S_WALK:   state_next = S_WCHK;
            S_WCHK:   state_next = stat.u_zero ? S_FIN : S_WK;
            S_WK:     state_next = stat.nfp_hit ? S_WK2 : S_DSTART;
            S_WK2:    state_next = stat.found_hit ? S_FIN : S_MARK;
            S_MARK:   state_next = S_MARK2;
            S_MARK2:  state_next = stat.chain_hit ? S_MARK : S_DSTART;
            S_DSTART: state_next = S_DS2;
            S_DS2:
            begin
                if (stat.dict_hit)
                    state_next = S_WCHK;
                else
                begin
                    ret_next   = RET_DICT;
                    state_next = S_FCHK;
                end
            end
            S_DRET:   state_next = S_DLOOP;
            S_DLOOP:  state_next = stat.w_zero ? S_WCHK : S_DL2;
            S_DL2:
            begin
                if (stat.nfp_hit || stat.dict_hit)
                    state_next = S_WCHK;
                else
                begin
                    ret_next   = RET_DICT;
                    state_next = S_FCHK;
                end
            end
            S_FIN:    if (stat.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mpm_dpath.sv =====
`default_nettype none

`include "multi_pattern_matcher_top_defines.svh"

module mpm_dpath
    import mpm_pkg::*;
#(
    parameter int TRIE_NODES = 4096,
    parameter int ALPHABET   = 28,
    parameter int PATTERNS   = 1024,
    parameter int MAX_DEPTH  = 64
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  mpm_cmd_t             cmd,
    input  wire [OP_W-1:0]       operation,
    input  wire [SYM_W-1:0]      symbol,
    input  wire [ID_W-1:0]       pattern_id,
    input  wire                  out_ready,
    output mpm_stat_t            stat,
    output logic                 out_valid,
    output logic                 found,
    output logic [STATUS_W-1:0]  status
);

    localparam int NW  = $clog2(TRIE_NODES);
    localparam int CW  = $clog2(TRIE_NODES + 1);
    localparam int TAB = TRIE_NODES * ALPHABET;
    localparam int TW  = $clog2(TAB);
    localparam int PW  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
    localparam int DW  = $clog2(MAX_DEPTH + 1);
    localparam int STK = MAX_DEPTH + 1;
    localparam int KW  = $clog2(STK);
    localparam int SPW = $clog2(STK + 1);
    localparam int CLR = (TAB > PATTERNS) ? TAB : PATTERNS;
    localparam int CLW = $clog2(CLR);
    localparam int PSW = SYM_W + NW;

    logic [NW-1:0]  child_mem  [TAB];
    logic [NW:0]    trans_mem  [TAB];
    logic [PSW-1:0] parent_mem [TRIE_NODES];
    logic [NW:0]    fail_mem   [TRIE_NODES];
    logic [NW:0]    dict_mem   [TRIE_NODES];
    logic [PW:0]    nfp_mem    [TRIE_NODES];
    logic [PW:0]    chain_mem  [PATTERNS];
    logic           found_mem  [PATTERNS];
    logic           used_mem   [PATTERNS];
    logic [NW-1:0]  stk_mem    [STK];

    logic           child_we, trans_we, parent_we, fail_we, dict_we;
    logic           nfp_we, chain_we, found_we, used_we, stk_we;
    logic [TW-1:0]  child_wa, trans_wa;
    logic [NW-1:0]  parent_wa, fail_wa, dict_wa, nfp_wa;
    logic [PW-1:0]  chain_wa, found_wa, used_wa;
    logic [KW-1:0]  stk_wa;
    logic [NW-1:0]  child_wd, stk_wd;
    logic [NW:0]    trans_wd, fail_wd, dict_wd;
    logic [PSW-1:0] parent_wd;
    logic [PW:0]    nfp_wd, chain_wd;
    logic           found_wd;
    logic [NW-1:0]  fail_ra, dict_ra, nfp_ra;
    logic [PW-1:0]  found_ra;
    logic [NW-1:0]  child_q, stk_q;
    logic [NW:0]    trans_q, fail_q, dict_q;
    logic [PSW-1:0] parent_q;
    logic [PW:0]    nfp_q, chain_q;
    logic           found_q, used_q;

    op_t            op_reg, op_next;
    logic [SYM_W-1:0] sym_reg, sym_next, c_reg, c_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [NW-1:0]  ins_reg, ins_next, tp_reg, tp_next, v_reg, v_next;
    logic [NW-1:0]  y_reg, y_next, x_reg, x_next, gx_reg, gx_next;
    logic [NW-1:0]  u_reg, u_next, w_reg, w_next, fres_reg, fres_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [PW-1:0]  k_reg, k_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [CLW-1:0] clr_reg, clr_next;
    logic           started_reg, started_next;
    logic           res_found_reg, res_found_next;
    status_t        res_status_reg, res_status_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_found_reg, out_found_next;
    status_t        out_status_reg, out_status_next;

    logic [NW-1:0]    cnode;
    logic [SYM_W-1:0] csym;
    logic [TW-1:0]    child_addr, trans_addr;
    logic [PW-1:0]    id_idx;
    logic             sym_bad, id_bad, full, clr_child, clr_node, clr_pat;
    status_t          err_code;

    assign id_idx    = PW'(id_reg);
    assign sym_bad   = int'(sym_reg) >= ALPHABET;
    assign id_bad    = int'(id_reg) >= PATTERNS;
    assign full      = (count_reg >= CW'(TRIE_NODES)) || (depth_reg >= DW'(MAX_DEPTH));
    assign clr_child = int'(clr_reg) < TAB;
    assign clr_node  = int'(clr_reg) < TRIE_NODES;
    assign clr_pat   = int'(clr_reg) < PATTERNS;

    always_comb
    begin
        unique case (op_t'(op_reg))
            OP_PAT_SYM: err_code = started_reg ? ST_PATTERN_AFTER_TXT :
                                   (sym_bad ? ST_BAD_SYMBOL : ST_OK);
            OP_PAT_END: err_code = started_reg ? ST_PATTERN_AFTER_TXT :
                                   (id_bad ? ST_BAD_ID : ST_OK);
            OP_TEXT:    err_code = sym_bad ? ST_BAD_SYMBOL : ST_OK;
            OP_QUERY:   err_code = id_bad ? ST_BAD_ID : ST_OK;
        endcase
    end

    always_comb
    begin
        unique case (cmd.step)
            S_GOX:
            begin
                cnode = gx_reg;
                csym  = sym_reg;
            end
            S_FX, S_FX2:
            begin
                cnode = x_reg;
                csym  = c_reg;
            end
            default:
            begin
                cnode = ins_reg;
                csym  = sym_reg;
            end
        endcase
    end

    assign child_addr = TW'(cnode) * TW'(ALPHABET) + TW'(csym);
    assign trans_addr = TW'(tp_reg) * TW'(ALPHABET) + TW'(sym_reg);

    assign stat.clr_done   = clr_reg == CLW'(CLR - 1);
    assign stat.op         = op_reg;
    assign stat.err        = err_code != ST_OK;
    assign stat.trans_hit  = trans_q[NW];
    assign stat.child_hit  = child_q != '0;
    assign stat.gx_zero    = gx_reg == '0;
    assign stat.x_zero     = x_reg == '0;
    assign stat.fail_hit   = fail_q[NW];
    assign stat.y_term     = (y_reg == '0) || (parent_q[NW-1:0] == '0);
    assign stat.sp_zero    = sp_reg == '0;
    assign stat.stack_full = sp_reg >= SPW'(STK);
    assign stat.u_zero     = u_reg == '0;
    assign stat.w_zero     = w_reg == '0;
    assign stat.nfp_hit    = nfp_q[PW];
    assign stat.found_hit  = found_q;
    assign stat.chain_hit  = chain_q[PW];
    assign stat.dict_hit   = dict_q[NW];
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        child_we  = 1'b0;
        child_wa  = child_addr;
        child_wd  = NW'(count_reg);
        trans_we  = 1'b0;
        trans_wa  = trans_addr;
        trans_wd  = {1'b1, stat.child_hit ? child_q : NW'(0)};
        parent_we = 1'b0;
        parent_wa = NW'(count_reg);
        parent_wd = {sym_reg, ins_reg};
        fail_we   = 1'b0;
        fail_wa   = y_reg;
        fail_wd   = {1'b1, NW'(0)};
        dict_we   = 1'b0;
        dict_wa   = u_reg;
        dict_wd   = {1'b1, NW'(0)};
        nfp_we    = 1'b0;
        nfp_wa    = ins_reg;
        nfp_wd    = {1'b1, id_idx};
        chain_we  = 1'b0;
        chain_wa  = id_idx;
        chain_wd  = nfp_q;
        found_we  = 1'b0;
        found_wa  = k_reg;
        found_wd  = 1'b1;
        used_we   = 1'b0;
        used_wa   = id_idx;
        stk_we    = 1'b0;
        stk_wa    = KW'(sp_reg);
        stk_wd    = v_reg;
        fail_ra   = v_reg;
        dict_ra   = u_reg;
        nfp_ra    = ins_reg;
        found_ra  = id_idx;
        unique case (cmd.step)
            S_CLEAR:
            begin
                child_we  = clr_child;
                child_wa  = TW'(clr_reg);
                child_wd  = '0;
                trans_we  = clr_child;
                trans_wa  = TW'(clr_reg);
                trans_wd  = '0;
                parent_we = clr_node;
                parent_wa = NW'(clr_reg);
                parent_wd = '0;
                fail_we   = clr_node;
                fail_wa   = NW'(clr_reg);
                fail_wd   = '0;
                dict_we   = clr_node;
                dict_wa   = NW'(clr_reg);
                dict_wd   = '0;
                nfp_we    = clr_node;
                nfp_wa    = NW'(clr_reg);
                nfp_wd    = '0;
                chain_we  = clr_pat;
                chain_wa  = PW'(clr_reg);
                chain_wd  = '0;
                found_we  = clr_pat;
                found_wa  = PW'(clr_reg);
                found_wd  = 1'b0;
                used_we   = clr_pat;
                used_wa   = PW'(clr_reg);
            end
            S_PAT:
            begin
                child_we  = !stat.child_hit && !full;
                parent_we = !stat.child_hit && !full;
            end
            S_END:
            begin
                nfp_we   = !used_q;
                chain_we = !used_q;
                used_we  = !used_q;
            end
            S_GOX2:   trans_we = stat.child_hit || stat.gx_zero;
            S_FCHK2:  stk_we = !stat.fail_hit;
            S_FY:     fail_ra = y_reg;
            S_FY2:    fail_we = stat.y_term && !stat.fail_hit;
            S_FP:     fail_ra = x_reg;
            S_FX:     fail_ra = x_reg;
            S_FX2:
            begin
                fail_we = stat.child_hit || stat.x_zero;
                fail_wd = {1'b1, stat.child_hit ? child_q : NW'(0)};
            end
            S_PUSH:
            begin
                fail_we = stat.stack_full;
                stk_we  = !stat.stack_full;
                stk_wd  = x_reg;
            end
            S_WCHK:   nfp_ra = u_reg;
            S_WK:     found_ra = nfp_q[PW-1:0];
            S_MARK:   found_we = 1'b1;
            S_DLOOP:
            begin
                dict_we = stat.w_zero;
                dict_ra = w_reg;
                nfp_ra  = w_reg;
            end
            S_DL2:
            begin
                dict_we = stat.nfp_hit || stat.dict_hit;
                dict_wd = {1'b1, stat.nfp_hit ? w_reg : dict_q[NW-1:0]};
            end
            default:  ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (child_we)
            child_mem[child_wa] <= child_wd;
        child_q <= child_mem[child_addr];
    end

    always_ff @(posedge clk)
    begin
        if (trans_we)
            trans_mem[trans_wa] <= trans_wd;
        trans_q <= trans_mem[trans_addr];
    end

    always_ff @(posedge clk)
    begin
        if (parent_we)
            parent_mem[parent_wa] <= parent_wd;
        parent_q <= parent_mem[y_reg];
    end

    always_ff @(posedge clk)
    begin
        if (fail_we)
            fail_mem[fail_wa] <= fail_wd;
        fail_q <= fail_mem[fail_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dict_we)
            dict_mem[dict_wa] <= dict_wd;
        dict_q <= dict_mem[dict_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nfp_we)
            nfp_mem[nfp_wa] <= nfp_wd;
        nfp_q <= nfp_mem[nfp_ra];
    end

    always_ff @(posedge clk)
    begin
        if (chain_we)
            chain_mem[chain_wa] <= chain_wd;
        chain_q <= chain_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (found_we)
            found_mem[found_wa] <= found_wd;
        found_q <= found_mem[found_ra];
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
            used_mem[used_wa] <= !stat.clr_done && (cmd.step == S_CLEAR) ? 1'b0 :
                                 (cmd.step != S_CLEAR);
        used_q <= used_mem[id_idx];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_wa] <= stk_wd;
        stk_q <= stk_mem[KW'(sp_reg - SPW'(1))];
    end

    always_comb
    begin
        op_next         = op_reg;
        sym_next        = sym_reg;
        id_next         = id_reg;
        c_next          = c_reg;
        ins_next        = ins_reg;
        tp_next         = tp_reg;
        v_next          = v_reg;
        y_next          = y_reg;
        x_next          = x_reg;
        gx_next         = gx_reg;
        u_next          = u_reg;
        w_next          = w_reg;
        fres_next       = fres_reg;
        depth_next      = depth_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        sp_next         = sp_reg;
        clr_next        = clr_reg;
        started_next    = started_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        unique case (cmd.step)
            S_CLEAR:  clr_next = clr_reg + 1'b1;
            S_IDLE:
            begin
                if (cmd.in_take)
                begin
                    op_next  = op_t'(operation);
                    sym_next = symbol;
                    id_next  = pattern_id;
                end
            end
            S_DECODE:
            begin
                res_found_next  = 1'b0;
                res_status_next = err_code;
                if (op_reg == OP_TEXT && err_code == ST_OK)
                    started_next = 1'b1;
            end
            S_PAT:
            begin
                priority if (stat.child_hit)
                begin
                    ins_next   = child_q;
                    depth_next = depth_reg + 1'b1;
                end
                else if (full)
                    res_status_next = ST_TRIE_FULL;
                else
                begin
                    ins_next   = NW'(count_reg);
                    depth_next = depth_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            S_END:
            begin
                if (used_q)
                    res_status_next = ST_BAD_ID;
                else
                begin
                    ins_next   = '0;
                    depth_next = '0;
                end
            end
            S_QUERY:  res_found_next = found_q;
            S_GO:
            begin
                if (stat.trans_hit)
                    tp_next = trans_q[NW-1:0];
                else
                    gx_next = tp_reg;
            end
            S_GOX2:
            begin
                priority if (stat.child_hit)
                    tp_next = child_q;
                else if (stat.gx_zero)
                    tp_next = '0;
                else
                    v_next = gx_reg;
            end
            S_GORET:  gx_next = fres_reg;
            S_FCHK2:
            begin
                if (stat.fail_hit)
                    fres_next = fail_q[NW-1:0];
                else
                begin
                    sp_next = SPW'(1);
                    y_next  = v_reg;
                end
            end
            S_FTOP2:  y_next = stk_q;
            S_FY2:
            begin
                if (!(stat.fail_hit || stat.y_term))
                begin
                    x_next = parent_q[NW-1:0];
                    c_next = parent_q[PSW-1:NW];
                end
            end
            S_FP2:    if (stat.fail_hit) x_next = fail_q[NW-1:0];
            S_FX2:
            begin
                if (!stat.child_hit && !stat.x_zero && stat.fail_hit)
                    x_next = fail_q[NW-1:0];
            end
            S_PUSH:
            begin
                if (!stat.stack_full)
                begin
                    sp_next = sp_reg + 1'b1;
                    y_next  = x_reg;
                end
            end
            S_POP:    sp_next = sp_reg - 1'b1;
            S_FRET2:  fres_next = fail_q[NW-1:0];
            S_WALK:   u_next = tp_reg;
            S_WK:     k_next = nfp_q[PW-1:0];
            S_MARK2:  k_next = chain_q[PW-1:0];
            S_DS2:
            begin
                if (stat.dict_hit)
                    u_next = dict_q[NW-1:0];
                else
                    v_next = u_reg;
            end
            S_DRET:   w_next = fres_reg;
            S_DLOOP:  if (stat.w_zero) u_next = '0;
            S_DL2:
            begin
                priority if (stat.nfp_hit)
                    u_next = w_reg;
                else if (stat.dict_hit)
                    u_next = dict_q[NW-1:0];
                else
                    v_next = w_reg;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ins_reg        <= '0;
            tp_reg         <= '0;
            depth_reg      <= '0;
            count_reg      <= CW'(1);
            sp_reg         <= '0;
            clr_reg        <= '0;
            started_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ins_reg        <= ins_next;
            tp_reg         <= tp_next;
            depth_reg      <= depth_next;
            count_reg      <= count_next;
            sp_reg         <= sp_next;
            clr_reg        <= clr_next;
            started_reg    <= started_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        sym_reg        <= sym_next;
        id_reg         <= id_next;
        c_reg          <= c_next;
        v_reg          <= v_next;
        y_reg          <= y_next;
        x_reg          <= x_next;
        gx_reg         <= gx_next;
        u_reg          <= u_next;
        w_reg          <= w_next;
        fres_reg       <= fres_next;
        k_reg          <= k_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign status    = out_status_reg;

    `MPM_ASSERT_ALWAYS(a_stack_bound, clk, rst_n, sp_reg <= SPW'(STK))
    `MPM_ASSERT_ALWAYS(a_count_bound, clk, rst_n, (count_reg != '0) && (count_reg <= CW'(TRIE_NODES)))
    `MPM_ASSERT_ALWAYS(a_text_node, clk, rst_n, CW'(tp_reg) < count_reg)
    `MPM_ASSERT_NEXT(a_started_sticky, clk, rst_n, started_reg, started_reg)

endmodule

`default_nettype wire

// ===== rtl/multi_pattern_matcher_top.sv =====
// Channel   Handshake             Word
// input     in_valid / in_ready   operation, symbol, pattern_id
// output    out_valid / out_ready found, status
//
// One word is processed at a time; in_ready is low from acceptance until the result is held.
// A word rejected with an error goes from decode straight to its result; a pattern symbol,
// pattern end or query is handled in a state of its own; a text word follows the goto and
// failure links, then walks the dictionary chain and marks the patterns that end there.
// After reset the memories are cleared one address a cycle, over 114688 addresses by default.
// A result waiting for out_ready holds the current word in its final state and so stalls the next word.
`default_nettype none

module multi_pattern_matcher_top
    import mpm_pkg::*;
#(
    parameter int TRIE_NODES = 4096,
    parameter int ALPHABET   = 28,
    parameter int PATTERNS   = 1024,
    parameter int MAX_DEPTH  = 64
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire [OP_W-1:0]       operation,
    input  wire [SYM_W-1:0]      symbol,
    input  wire [ID_W-1:0]       pattern_id,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic                 found,
    output logic [STATUS_W-1:0]  status
);

    mpm_cmd_t  cmd;
    mpm_stat_t stat;

    mpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    mpm_dpath #(
        .TRIE_NODES (TRIE_NODES),
        .ALPHABET   (ALPHABET),
        .PATTERNS   (PATTERNS),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .operation  (operation),
        .symbol     (symbol),
        .pattern_id (pattern_id),
        .out_ready  (out_ready),
        .stat       (stat),
        .out_valid  (out_valid),
        .found      (found),
        .status     (status)
    );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import mpm_pkg::*;

    localparam int NODES   = 4096;
    localparam int ALPH    = 28;
    localparam int NPAT    = 1024;
    localparam int DEPTH   = 64;
    localparam int LIMIT   = 4000000;

    typedef struct {
        logic    found;
        status_t st;
    } answer_t;

    class match_scoreboard;
        int      kid[NODES*ALPH];
        int      trans[NODES*ALPH];
        int      par[NODES];
        int      psym[NODES];
        int      flink[NODES];
        int      dlink[NODES];
        int      first_id[NODES];
        int      next_id[NPAT];
        bit      marked[NPAT];
        bit      taken[NPAT];
        int      nodes;
        int      ins_pos;
        int      ins_depth;
        int      txt_pos;
        bit      in_text;
        answer_t awaited[$];
        int      errors;

        function new();
            foreach (kid[i])
            begin
                kid[i] = 0;
                trans[i] = -1;
            end
            foreach (par[i])
            begin
                par[i] = 0;
                psym[i] = 0;
                flink[i] = -1;
                dlink[i] = -1;
                first_id[i] = -1;
            end
            foreach (next_id[i])
            begin
                next_id[i] = -1;
                marked[i] = 0;
                taken[i] = 0;
            end
            nodes = 1;
            ins_pos = 0;
            ins_depth = 0;
            txt_pos = 0;
            in_text = 0;
            errors = 0;
        endfunction

        function int fail_of(int v);
            int x;
            int c;
            int r;
            if (flink[v] >= 0)
                return flink[v];
            if (v == 0 || par[v] == 0)
            begin
                flink[v] = 0;
                return 0;
            end
            c = psym[v];
            x = fail_of(par[v]);
            forever
            begin
                if (kid[x*ALPH+c] != 0)
                begin
                    r = kid[x*ALPH+c];
                    break;
                end
                if (x == 0)
                begin
                    r = 0;
                    break;
                end
                x = fail_of(x);
            end
            flink[v] = r;
            return r;
        endfunction

        function int next_state(int v, int c);
            int x;
            int r;
            if (trans[v*ALPH+c] >= 0)
                return trans[v*ALPH+c];
            x = v;
            forever
            begin
                if (kid[x*ALPH+c] != 0)
                begin
                    r = kid[x*ALPH+c];
                    break;
                end
                if (x == 0)
                begin
                    r = 0;
                    break;
                end
                x = fail_of(x);
            end
            trans[v*ALPH+c] = r;
            return r;
        endfunction

        function int output_link(int v);
            int u;
            int r;
            if (dlink[v] >= 0)
                return dlink[v];
            u = fail_of(v);
            forever
            begin
                if (u == 0)
                begin
                    r = 0;
                    break;
                end
                if (first_id[u] >= 0)
                begin
                    r = u;
                    break;
                end
                if (dlink[u] >= 0)
                begin
                    r = dlink[u];
                    break;
                end
                u = fail_of(u);
            end
            dlink[v] = r;
            return r;
        endfunction

        function void note_word(op_t op, logic [SYM_W-1:0] sym, logic [ID_W-1:0] id);
            answer_t a;
            int      ch;
            int      u;
            int      k;
            a.found = 0;
            a.st = ST_OK;
            case (op)
                OP_PAT_SYM:
                begin
                    if (in_text)
                        a.st = ST_PATTERN_AFTER_TXT;
                    else if (sym >= ALPH)
                        a.st = ST_BAD_SYMBOL;
                    else
                    begin
                        ch = kid[ins_pos*ALPH+sym];
                        if (ch != 0)
                        begin
                            ins_pos = ch;
                            ins_depth++;
                        end
                        else if (nodes >= NODES || ins_depth >= DEPTH)
                            a.st = ST_TRIE_FULL;
                        else
                        begin
                            kid[ins_pos*ALPH+sym] = nodes;
                            par[nodes] = ins_pos;
                            psym[nodes] = sym;
                            ins_pos = nodes;
                            ins_depth++;
                            nodes++;
                        end
                    end
                end
                OP_PAT_END:
                begin
                    if (in_text)
                        a.st = ST_PATTERN_AFTER_TXT;
                    else if (id >= NPAT || taken[id])
                        a.st = ST_BAD_ID;
                    else
                    begin
                        taken[id] = 1;
                        next_id[id] = first_id[ins_pos];
                        first_id[ins_pos] = id;
                        ins_pos = 0;
                        ins_depth = 0;
                    end
                end
                OP_TEXT:
                begin
                    if (sym >= ALPH)
                        a.st = ST_BAD_SYMBOL;
                    else
                    begin
                        in_text = 1;
                        txt_pos = next_state(txt_pos, sym);
                        u = txt_pos;
                        while (u != 0)
                        begin
                            k = first_id[u];
                            if (k >= 0 && marked[k])
                                break;
                            while (k >= 0 && k < NPAT)
                            begin
                                marked[k] = 1;
                                k = next_id[k];
                            end
                            u = output_link(u);
                        end
                    end
                end
                default:
                begin
                    if (id >= NPAT)
                        a.st = ST_BAD_ID;
                    else
                        a.found = marked[id];
                end
            endcase
            awaited.insert(awaited.size(), a);
        endfunction

        function void check_result(logic f, logic [STATUS_W-1:0] s);
            answer_t a;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, found %0d status %0d",
                         $time, f, s);
                errors++;
                return;
            end
            a = awaited.pop_front();
            if (f !== a.found)
            begin
                $display("%0t: found mismatch, expected %0d actual %0d", $time, a.found, f);
                errors++;
            end
            if (s !== a.st)
            begin
                $display("%0t: status mismatch, expected %0d actual %0d", $time, a.st, s);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 0;
    logic                rst_n = 0;
    logic                in_valid = 0;
    logic                in_ready;
    logic [OP_W-1:0]     operation = '0;
    logic [SYM_W-1:0]    symbol = '0;
    logic [ID_W-1:0]     pattern_id = '0;
    logic                out_valid;
    logic                out_ready = 0;
    logic                found;
    logic [STATUS_W-1:0] status;

    match_scoreboard sb = new();
    int gap_pct = 0;
    int stall_pct = 0;
    int word_count = 0;
    int cycles = 0;
    int k;
    int n;
    int len;
    int r;

    multi_pattern_matcher_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .symbol     (symbol),
        .pattern_id (pattern_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .status     (status)
    );

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(found, status);

    function automatic logic [SYM_W-1:0] pick_symbol();
        int p;
        p = $urandom_range(99);
        if (p < 80)
            return SYM_W'($urandom_range(3));
        if (p < 95)
            return SYM_W'($urandom_range(ALPH - 1));
        return SYM_W'($urandom_range(31, ALPH));
    endfunction

    task automatic set_phase();
        case ((word_count / 250) % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 55; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 55; end
            default: begin gap_pct = 7; stall_pct = 7; end
        endcase
    endtask

    task automatic send_word(op_t op, logic [SYM_W-1:0] sym, logic [ID_W-1:0] id);
        set_phase();
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1;
        operation <= op;
        symbol <= sym;
        pattern_id <= id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_word(op, sym, id);
        word_count++;
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic add_pattern(int size, logic [ID_W-1:0] id);
        for (int i = 0; i < size; i++)
            send_word(OP_PAT_SYM, pick_symbol(), id);
        send_word(OP_PAT_END, SYM_W'($urandom_range(31)), id);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_word(OP_QUERY, 0, 0);
        send_word(OP_PAT_SYM, 28, 0);
        send_word(OP_PAT_SYM, 31, 1023);
        send_word(OP_PAT_SYM, 0, 0);
        send_word(OP_PAT_SYM, 1, 0);
        send_word(OP_PAT_END, 0, 0);
        send_word(OP_PAT_END, 0, 1023);
        send_word(OP_PAT_END, 0, 0);
        send_word(OP_PAT_SYM, ALPH - 1, 0);
        send_word(OP_PAT_END, 0, 512);
        for (int i = 0; i < DEPTH + 2; i++)
            send_word(OP_PAT_SYM, ALPH - 1, 0);
        send_word(OP_PAT_END, 31, 341);
        send_word(OP_PAT_SYM, 2, 682);
        send_word(OP_PAT_END, 2, 682);

        n = 0;
        while (n < 160)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send_word(OP_PAT_SYM, SYM_W'($urandom_range(31, ALPH)), ID_W'($urandom));
            else if (r < 14)
                send_word(OP_PAT_END, SYM_W'($urandom_range(31)),
                          ID_W'($urandom_range(NPAT - 1)));
            else
            begin
                k = $urandom_range(NPAT - 1);
                while (sb.taken[k])
                    k = $urandom_range(NPAT - 1);
                len = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
                add_pattern(len, ID_W'(k));
            end
            n++;
        end

        drain();

        send_word(OP_TEXT, 29, 0);
        send_word(OP_PAT_SYM, 0, 0);
        send_word(OP_TEXT, 0, 0);
        send_word(OP_TEXT, 1, 0);
        send_word(OP_QUERY, 0, 0);
        send_word(OP_QUERY, 0, 1023);
        send_word(OP_PAT_SYM, 3, 0);
        send_word(OP_PAT_END, 0, 7);
        for (int i = 0; i < DEPTH + 4; i++)
            send_word(OP_TEXT, ALPH - 1, 0);
        send_word(OP_QUERY, 0, 341);
        send_word(OP_QUERY, 0, 512);

        while (word_count < 1800)
        begin
            if (word_count % 400 == 0)
                drain();
            r = $urandom_range(99);
            if (r < 70)
                send_word(OP_TEXT, pick_symbol(), ID_W'($urandom));
            else if (r < 72)
                for (int i = 0; i < $urandom_range(3, 12); i++)
                    send_word(OP_TEXT, ALPH - 1, 0);
            else if (r < 95)
                send_word(OP_QUERY, SYM_W'($urandom), ID_W'($urandom_range(NPAT - 1)));
            else
                send_word(op_t'($urandom_range(1)), SYM_W'($urandom), ID_W'($urandom));
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mpm_pkg.sv
rtl/mpm_ctrl.sv
rtl/mpm_dpath.sv
rtl/multi_pattern_matcher_top.sv
dv/tb_top.sv
